// ----- rtl/wps_pkg.sv -----
// ============================================================================
// wps_pkg
// Shared types and constants for the WAV PCM16 stream parser.
// ============================================================================
package wps_pkg;

    // RIFF/WAVE tags, big-endian as they arrive byte by byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // fmt chunk values accepted for output
    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [15:0] PCM_DEPTH   = 16'd16;
    localparam logic [15:0] CHAN_MONO   = 16'd1;
    localparam logic [15:0] CHAN_STEREO = 16'd2;

    // Byte counter only needs to tell positions below the minimum header size
    localparam int          BIDX_W         = 4;
    localparam logic [BIDX_W-1:0] BIDX_SAT = 4'd12;
    localparam logic [BIDX_W-1:0] BIDX_RIFF_END = 4'd3;
    localparam logic [BIDX_W-1:0] BIDX_WAVE_END = 4'd11;

    // Chunk header is 8 bytes: tag then little-endian length
    localparam logic [4:0]  HDR_LAST = 5'd7;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_RATE = 1'd1;

    localparam logic [23:0] MAX_SAMPLES_RST   = 24'd480000;
    localparam logic [31:0] EXPECTED_RATE_RST = 32'd48000;

    // Output queue, power of two deep
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_DATA = 3'd3,
        PH_SKIP = 3'd4,
        PH_SINK = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_TAGS   = 3'd2,
        ST_MISSING    = 3'd3,
        ST_NOT_PCM    = 3'd4,
        ST_NOT_16BIT  = 3'd5,
        ST_DATA_FIRST = 3'd6,
        ST_BAD_CHAN   = 3'd7
    } status_t;

    typedef struct packed {
        logic fmt;
        logic data;
        logic nz;
        logic trunc;
    } flags_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        status_t     status;
        logic [23:0] sample_count;
        logic [15:0] channel_count;
        logic [31:0] file_rate;
        logic        truncated;
        logic        rate_mismatch;
        logic        final_item;
    } result_t;

    // Up to two results per accepted byte: a sample, then the status item
    typedef struct packed {
        logic    smp_valid;
        logic    stat_valid;
        result_t smp;
        result_t stat;
    } push_t;

endpackage

// ----- rtl/wps_parse.sv -----
// ============================================================================
// wps_parse
// Byte-wise RIFF/WAVE parser: header check, chunk walk, fmt capture and
// mono downmix of the data chunk. One byte per cycle.
// ============================================================================
module wps_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_eof,
    input  logic [23:0]     max_samples,
    input  logic [31:0]     expected_rate,
    output wps_pkg::push_t  push
);

    wps_pkg::phase_t  phase_reg,   phase_next;
    logic [wps_pkg::BIDX_W-1:0] byte_idx_reg, byte_idx_step, byte_idx_next;
    logic [31:0]      tag_reg,     tag_step,     tag_next;
    logic [31:0]      len_reg,     len_step,     len_next;
    logic [4:0]       pos_reg,     pos_step,     pos_next;
    logic [15:0]      format_reg,  format_step,  format_next;
    logic [15:0]      chan_reg,    chan_step,    chan_next;
    logic [31:0]      rate_reg,    rate_step,    rate_next;
    logic [15:0]      depth_reg,   depth_step,   depth_next;
    wps_pkg::flags_t  flags_reg,   flags_step,   flags_next;
    logic [31:0]      frame_reg,   frame_step,   frame_next;
    logic [23:0]      emitted_reg, emitted_step, emitted_next;
    wps_pkg::status_t err_reg,     err_step,     err_next;

    // shared byte-level terms
    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [31:0] len_dec;
    logic [4:0]  pos_inc;
    logic [31:0] frame_shift;
    logic        riff_bad;
    logic        riff_done;
    logic        hdr_done;
    logic        body_end;
    logic        is_fmt;
    logic        is_data;
    logic        fmt_ok;
    wps_pkg::phase_t disp_phase;
    logic        frame_done;
    logic        smp_emit;
    logic [16:0] pair_sum;
    logic [16:0] pair_adj;
    logic [15:0] smp_value;
    wps_pkg::status_t final_status;

    assign tag_shift   = {tag_reg[23:0], in_byte};
    assign len_shift   = {in_byte, len_reg[31:8]};
    assign len_dec     = len_reg - 32'd1;
    // low nibble wraps (frame phase), bit 4 sticks once past 15 (fmt offsets)
    assign pos_inc     = {pos_reg[4] | (pos_reg[3:0] == 4'hF), pos_reg[3:0] + 4'd1};
    assign frame_shift = {in_byte, frame_reg[31:8]};

    assign riff_bad  = ((byte_idx_reg == wps_pkg::BIDX_RIFF_END) &&
                        (tag_shift != wps_pkg::TAG_RIFF)) ||
                       ((byte_idx_reg == wps_pkg::BIDX_WAVE_END) &&
                        (tag_shift != wps_pkg::TAG_WAVE));
    assign riff_done = (byte_idx_reg == wps_pkg::BIDX_WAVE_END);
    assign hdr_done  = (pos_reg == wps_pkg::HDR_LAST);
    assign body_end  = (len_dec == 32'd0);

    // chunk dispatch at the last header byte
    assign is_fmt  = (tag_reg == wps_pkg::TAG_FMT) && !flags_reg.fmt;
    assign is_data = (tag_reg == wps_pkg::TAG_DATA) && !flags_reg.data;
    assign fmt_ok  = (format_reg == wps_pkg::FMT_PCM) &&
                     (depth_reg == wps_pkg::PCM_DEPTH) &&
                     ((chan_reg == wps_pkg::CHAN_MONO) ||
                      (chan_reg == wps_pkg::CHAN_STEREO));

    always_comb begin
        if (len_shift == 32'd0) begin
            disp_phase = wps_pkg::PH_HDR;
        end else if (is_fmt) begin
            disp_phase = wps_pkg::PH_FMT;
        end else if (is_data && flags_reg.fmt && fmt_ok) begin
            disp_phase = wps_pkg::PH_DATA;
        end else begin
            disp_phase = wps_pkg::PH_SKIP;
        end
    end

    // a frame is complete on its last byte: 2 bytes mono, 4 bytes stereo
    assign frame_done = (chan_reg == wps_pkg::CHAN_STEREO) ? (pos_reg[1:0] == 2'd3)
                                                          : pos_reg[0];

    // stereo average, truncated toward zero
    assign pair_sum  = {frame_shift[15], frame_shift[15:0]} +
                       {frame_shift[31], frame_shift[31:16]};
    assign pair_adj  = pair_sum + 17'(pair_sum[16]);
    assign smp_value = (chan_reg == wps_pkg::CHAN_STEREO) ? pair_adj[16:1]
                                                          : frame_shift[31:16];

    // phase next state
    always_comb begin
        phase_next = phase_reg;
        if (in_valid) begin
            if (in_eof) begin
                phase_next = wps_pkg::PH_RIFF;
            end else begin
                case (phase_reg)
                    wps_pkg::PH_RIFF: begin
                        if (riff_bad) begin
                            phase_next = wps_pkg::PH_SINK;
                        end else if (riff_done) begin
                            phase_next = wps_pkg::PH_HDR;
                        end
                    end
                    wps_pkg::PH_HDR: begin
                        if (hdr_done) begin
                            phase_next = disp_phase;
                        end
                    end
                    wps_pkg::PH_FMT, wps_pkg::PH_DATA, wps_pkg::PH_SKIP: begin
                        if (body_end) begin
                            phase_next = wps_pkg::PH_HDR;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // datapath update for one byte
    always_comb begin
        byte_idx_step = (byte_idx_reg == wps_pkg::BIDX_SAT) ? byte_idx_reg
                                                            : byte_idx_reg + 4'd1;
        tag_step     = tag_reg;
        len_step     = len_reg;
        pos_step     = pos_reg;
        format_step  = format_reg;
        chan_step    = chan_reg;
        rate_step    = rate_reg;
        depth_step   = depth_reg;
        flags_step   = flags_reg;
        frame_step   = frame_reg;
        emitted_step = emitted_reg;
        err_step     = err_reg;
        smp_emit     = 1'b0;
        case (phase_reg)
            wps_pkg::PH_RIFF: begin
                tag_step = tag_shift;
                if (riff_bad) begin
                    err_step = wps_pkg::ST_BAD_TAGS;
                end else if (riff_done) begin
                    pos_step = '0;
                    tag_step = '0;
                end
            end
            wps_pkg::PH_HDR: begin
                if (!pos_reg[2]) begin
                    tag_step = tag_shift;
                end else begin
                    len_step = len_shift;
                end
                pos_step = pos_reg + 5'd1;
                if (hdr_done) begin
                    pos_step = '0;
                    if (is_fmt) begin
                        flags_step.fmt = 1'b1;
                    end else if (is_data) begin
                        flags_step.data = 1'b1;
                        if (len_shift != 32'd0) begin
                            flags_step.nz = 1'b1;
                        end
                        if (!flags_reg.fmt && (err_reg == wps_pkg::ST_OK)) begin
                            err_step = wps_pkg::ST_DATA_FIRST;
                        end
                    end
                end
            end
            wps_pkg::PH_FMT, wps_pkg::PH_DATA, wps_pkg::PH_SKIP: begin
                pos_step = pos_inc;
                len_step = len_dec;
                if (phase_reg == wps_pkg::PH_FMT) begin
                    // little-endian fields at fixed offsets of the fmt body
                    case (pos_reg)
                        5'd0:  format_step[7:0]  = in_byte;
                        5'd1:  format_step[15:8] = in_byte;
                        5'd2:  chan_step[7:0]    = in_byte;
                        5'd3:  chan_step[15:8]   = in_byte;
                        5'd4:  rate_step[7:0]    = in_byte;
                        5'd5:  rate_step[15:8]   = in_byte;
                        5'd6:  rate_step[23:16]  = in_byte;
                        5'd7:  rate_step[31:24]  = in_byte;
                        5'd14: depth_step[7:0]   = in_byte;
                        5'd15: depth_step[15:8]  = in_byte;
                        default: begin
                            format_step = format_reg;
                        end
                    endcase
                end
                if (phase_reg == wps_pkg::PH_DATA) begin
                    frame_step = frame_shift;
                    if (frame_done) begin
                        if (emitted_reg >= max_samples) begin
                            flags_step.trunc = 1'b1;
                        end else begin
                            smp_emit     = 1'b1;
                            emitted_step = emitted_reg + 24'd1;
                        end
                    end
                end
                if (body_end) begin
                    pos_step = '0;
                    tag_step = '0;
                end
            end
            default: begin
                tag_step = tag_reg;
            end
        endcase
    end

    // end of file status, taken from the updated state
    always_comb begin
        if (byte_idx_step < wps_pkg::BIDX_SAT) begin
            final_status = wps_pkg::ST_SHORT;
        end else if (err_step != wps_pkg::ST_OK) begin
            final_status = err_step;
        end else if (!(flags_step.fmt && flags_step.data && flags_step.nz)) begin
            final_status = wps_pkg::ST_MISSING;
        end else if (format_step != wps_pkg::FMT_PCM) begin
            final_status = wps_pkg::ST_NOT_PCM;
        end else if (depth_step != wps_pkg::PCM_DEPTH) begin
            final_status = wps_pkg::ST_NOT_16BIT;
        end else if ((chan_step != wps_pkg::CHAN_MONO) &&
                     (chan_step != wps_pkg::CHAN_STEREO)) begin
            final_status = wps_pkg::ST_BAD_CHAN;
        end else begin
            final_status = wps_pkg::ST_OK;
        end
    end

    // next values: hold when idle, clear after the last byte of a file
    always_comb begin
        byte_idx_next = byte_idx_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        format_next   = format_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        depth_next    = depth_reg;
        flags_next    = flags_reg;
        frame_next    = frame_reg;
        emitted_next  = emitted_reg;
        err_next      = err_reg;
        if (in_valid) begin
            if (in_eof) begin
                byte_idx_next = '0;
                tag_next      = '0;
                len_next      = '0;
                pos_next      = '0;
                format_next   = '0;
                chan_next     = '0;
                rate_next     = '0;
                depth_next    = '0;
                flags_next    = '0;
                frame_next    = '0;
                emitted_next  = '0;
                err_next      = wps_pkg::ST_OK;
            end else begin
                byte_idx_next = byte_idx_step;
                tag_next      = tag_step;
                len_next      = len_step;
                pos_next      = pos_step;
                format_next   = format_step;
                chan_next     = chan_step;
                rate_next     = rate_step;
                depth_next    = depth_step;
                flags_next    = flags_step;
                frame_next    = frame_step;
                emitted_next  = emitted_step;
                err_next      = err_step;
            end
        end
    end

    // result items
    always_comb begin
        push                     = '0;
        push.smp_valid           = in_valid && smp_emit;
        push.smp.sample          = smp_value;
        push.stat_valid          = in_valid && in_eof;
        push.stat.kind           = 1'b1;
        push.stat.status         = final_status;
        push.stat.sample_count   = emitted_step;
        push.stat.channel_count  = chan_step;
        push.stat.file_rate      = rate_step;
        push.stat.truncated      = flags_step.trunc;
        push.stat.rate_mismatch  = flags_step.fmt && (rate_step != expected_rate);
        push.stat.final_item     = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wps_pkg::PH_RIFF;
            byte_idx_reg <= '0;
            tag_reg      <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            format_reg   <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            depth_reg    <= '0;
            flags_reg    <= '0;
            frame_reg    <= '0;
            emitted_reg  <= '0;
            err_reg      <= wps_pkg::ST_OK;
        end else begin
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            format_reg   <= format_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            depth_reg    <= depth_next;
            flags_reg    <= flags_next;
            frame_reg    <= frame_next;
            emitted_reg  <= emitted_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ----- rtl/wps_ofifo.sv -----
// ============================================================================
// wps_ofifo
// Result queue: takes up to two items per cycle, hands out one per cycle while the reader is ready.
// ============================================================================
module wps_ofifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  wps_pkg::push_t    push,
    output logic              push_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output wps_pkg::result_t  m_item
);

    localparam int PW = wps_pkg::OFIFO_PTR_W;
    localparam int CW = wps_pkg::OFIFO_CNT_W;

    wps_pkg::result_t mem_reg [wps_pkg::OFIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [CW-1:0] n_push;
    logic [PW-1:0] stat_addr;
    logic          pop;

    // room for a worst-case pair of results
    assign push_ready = (cnt_reg <= CW'(wps_pkg::OFIFO_DEPTH - 2));
    assign m_valid    = (cnt_reg != '0);
    assign m_item     = mem_reg[rd_ptr_reg];
    assign pop        = m_valid && m_ready;

    assign n_push    = CW'(push.smp_valid) + CW'(push.stat_valid);
    assign stat_addr = push.smp_valid ? wr_ptr_reg + PW'(1) : wr_ptr_reg;

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push[PW-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + n_push - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, sample before status
    always_ff @(posedge aclk) begin
        if (push.smp_valid) begin
            mem_reg[wr_ptr_reg] <= push.smp;
        end
        if (push.stat_valid) begin
            mem_reg[stat_addr] <= push.stat;
        end
    end

endmodule

// ----- rtl/wav_pcm16_stream_parser_unit.sv -----
// ============================================================================
// wav_pcm16_stream_parser_unit
// WAV file parser that turns a byte stream into mono PCM16 samples and a
// per-file status item.
// ============================================================================
// The block takes one file byte per cycle on the slave stream (s_tlast on the
// final byte) unless stalled, and answers through a four-entry result queue.
// Each byte is handled by the parse stage as it is accepted, so the sustained
// rate is one byte per clock; the only stall comes from the queue, which drops
// s_tready whenever fewer than two entries are free (the last byte of a file
// can yield both a sample and the status item). Stereo frames are averaged
// toward zero, mono words pass through, and output stops at max_samples. After
// the status transaction the parser is back at its reset state for the next
// file; the configuration registers keep their values. No clearing pass runs
// after reset.
// ============================================================================
module wav_pcm16_stream_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // end_of_file
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] sample, [18:16] status, [42:19] sample_count,
    // [58:43] channel_count, [90:59] file_rate, [91] truncated,
    // [92] rate_mismatch, [95:93] zero
    output logic [95:0] m_tdata,
    output logic        m_tuser,    // kind
    output logic        m_tlast,    // final_item
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_wr_data
);

    logic [23:0]      max_samples_reg;
    logic [31:0]      expected_rate_reg;
    logic             in_valid;
    wps_pkg::push_t   push;
    wps_pkg::result_t m_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_samples_reg   <= wps_pkg::MAX_SAMPLES_RST;
            expected_rate_reg <= wps_pkg::EXPECTED_RATE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wps_pkg::CFG_MAX_SAMPLES:   max_samples_reg   <= cfg_wr_data[23:0];
                wps_pkg::CFG_EXPECTED_RATE: expected_rate_reg <= cfg_wr_data;
                default: begin
                    max_samples_reg <= max_samples_reg;
                end
            endcase
        end
    end

    assign in_valid = s_tvalid && s_tready;

    wps_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid),
        .in_byte       (s_tdata),
        .in_eof        (s_tlast),
        .max_samples   (max_samples_reg),
        .expected_rate (expected_rate_reg),
        .push          (push)
    );

    wps_ofifo u_ofifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_item     (m_item)
    );

    // result packing
    assign m_tdata = {3'b000, m_item.rate_mismatch, m_item.truncated, m_item.file_rate,
                      m_item.channel_count, m_item.sample_count, m_item.status,
                      m_item.sample};
    assign m_tuser = m_item.kind;
    assign m_tlast = m_item.final_item;

endmodule

// ----- rtl/wps_checker.sv -----
// ============================================================================
// wps_checker
// Port-level checks on the result stream of the WAV parser.
// ============================================================================
module wps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // the status item, and only it, closes a file
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("final marker does not match item kind");

    // sample items carry nothing but the sample
    a_smp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[95:16] == 80'd0))
        else $error("sample item carries status fields");

    // status items carry no sample and no stray padding
    a_stat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[15:0] == 16'd0) && (m_tdata[95:93] == 3'd0))
        else $error("status item carries sample bits");

endmodule

bind wav_pcm16_stream_parser_unit wps_checker u_wps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
